// ===== design/msb_first_bit_field_reader_writer_defines.svh =====
// Assertion macros for the MSB-first bit-field reader/writer checker.
`ifndef MSB_FIRST_BIT_FIELD_READER_WRITER_DEFINES_SVH
`define MSB_FIRST_BIT_FIELD_READER_WRITER_DEFINES_SVH

// Check on the next cycle, skipped while reset is high.
`define MSBBRW_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("msbbrw assertion failed");

// Check on the next cycle, also across reset.
`define MSBBRW_ASSERT_NEXT_ALWAYS(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("msbbrw assertion failed");

`endif

// ===== design/msbbrw_pkg.sv =====
// Types and constants shared by the MSB-first bit-field reader/writer.
package msbbrw_pkg;

  localparam int BYTE_BITS = 8;
  localparam int MAX_BITS  = 32;
  localparam int POS_W     = 13;
  localparam int LEN_W     = 13;
  localparam int ADDR_IN_W = 12;
  localparam int COUNT_W   = 6;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;
  localparam logic [POS_W-1:0] POS_MAX   = 13'h1FFF;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_READ   = 2'd1,
    REQ_WRITE  = 2'd2,
    REQ_REWIND = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_STEP,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    req_kind_t              req_type;
    logic [ADDR_IN_W-1:0]   byte_addr;
    logic [BYTE_BITS-1:0]   byte_value;
    logic [COUNT_W-1:0]     bit_count;
    logic [MAX_BITS-1:0]    write_value;
  } req_t;

  typedef struct packed {
    logic [MAX_BITS-1:0] read_value;
    logic                overflow;
    logic [POS_W-1:0]    next_byte_pos;
  } resp_t;

endpackage

// ===== design/msb_first_bit_field_reader_writer.sv =====
// MSB-first bit-field reader/writer over a byte buffer: top level.
//
// Requests enter on req (req_valid / req_stall) and each yields one response
// on resp (resp_valid / resp_stall). cfg_wen with cfg_wdata sets buffer_len;
// the user must write it only while the block is idle (not enforced).
// A read or write of n bits moves at most one byte chunk per cycle: a fetch
// issues a buffer read at the byte position, and the registered read data is
// consumed in the following cycle. When BUF_BYTES is not a power of two and
// is below 4096, a load reduces its address one remainder bit per cycle.
// The response sits in an output register; the next request is taken while
// it waits. A stalled response holds, and the engine stops ahead of it until
// the register frees up.
// Reset clears the position, the bit state, buffer_len (to 4096) and the
// response register; buffer contents are undefined until loaded.
module msb_first_bit_field_reader_writer import msbbrw_pkg::*; #(
  parameter int BUF_BYTES = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             resp_valid,
  input  logic             resp_stall,
  output resp_t            resp
);

  localparam int AW = $clog2(BUF_BYTES);

  state_t               state;
  state_t               state_next;
  logic [LEN_W-1:0]     buffer_len;
  logic [POS_W-1:0]     byte_pos;
  logic [AW-1:0]        ptr;
  logic [AW-1:0]        fetch_addr;
  logic [BYTE_BITS-1:0] cur_byte;
  logic [3:0]           bits_left;
  logic [COUNT_W-1:0]   count;
  req_kind_t            kind;
  logic [MAX_BITS-1:0]  acc;
  logic [MAX_BITS-1:0]  wsh;
  logic                 ovf;
  logic [BYTE_BITS-1:0] load_value;

  logic                 accept;
  logic [COUNT_W-1:0]   cnt_in;
  logic [BYTE_BITS-1:0] src;
  logic [3:0]           src_left;
  logic [3:0]           take;
  logic [3:0]           left_after;
  logic [COUNT_W-1:0]   count_after;
  logic [BYTE_BITS-1:0] shl;
  logic [BYTE_BITS-1:0] rd_bits;
  logic [BYTE_BITS-1:0] wr_bits;
  logic [BYTE_BITS-1:0] byte_new;
  logic                 fetch_need;
  logic                 step_go;
  logic                 finish;
  logic [AW-1:0]        ptr_inc;

  logic                 mod_start;
  logic                 mod_done;
  logic [AW-1:0]        mod_rem;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [BYTE_BITS-1:0] ram_wdata;
  logic [BYTE_BITS-1:0] ram_rdata;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign cnt_in    = (req.bit_count > COUNT_W'(MAX_BITS)) ? COUNT_W'(MAX_BITS) : req.bit_count;
  assign mod_start = accept && (req.req_type == REQ_LOAD);

  assign src         = (state == ST_FETCH) ? ram_rdata : cur_byte;
  assign src_left    = (state == ST_FETCH) ? 4'(BYTE_BITS) : bits_left;
  assign take        = ({2'b00, src_left} < count) ? src_left : count[3:0];
  assign left_after  = src_left - take;
  assign count_after = count - {2'b00, take};
  assign shl         = src << take;
  assign rd_bits     = src >> (4'(BYTE_BITS) - take);
  assign wr_bits     = wsh[MAX_BITS-1 -: BYTE_BITS] >> (4'(BYTE_BITS) - take);
  assign byte_new    = (kind == REQ_WRITE) ? (shl | wr_bits) : shl;

  assign fetch_need = (state == ST_STEP) && (count != '0) && (bits_left == '0);
  assign step_go    = ((state == ST_STEP) && (count != '0) && (bits_left != '0)) ||
                      (state == ST_FETCH);
  assign finish     = (state == ST_DONE) && (!resp_valid || !resp_stall);
  assign ptr_inc    = ((byte_pos == POS_MAX) || (ptr == AW'(BUF_BYTES - 1))) ?
                      '0 : ptr + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fetch_addr;
    ram_wdata = byte_new;
    if (state == ST_MOD) begin
      ram_we    = mod_done;
      ram_waddr = mod_rem;
      ram_wdata = load_value;
    end else if (step_go && (kind == REQ_WRITE) && (left_after == '0)) begin
      ram_we = 1'b1;
    end
  end

  msbbrw_addr_mod #(
    .BUF_BYTES(BUF_BYTES)
  ) u_addr_mod (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .addr (req.byte_addr),
    .done (mod_done),
    .rem  (mod_rem)
  );

  msbbrw_ram #(
    .WIDTH(BYTE_BITS),
    .DEPTH(BUF_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (fetch_need),
    .raddr(ptr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_LOAD:   state_next = ST_MOD;
            REQ_READ:   state_next = ST_STEP;
            REQ_WRITE:  state_next = ST_STEP;
            REQ_REWIND: state_next = ST_DONE;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_next = ST_DONE;
        end
      end
      ST_STEP: begin
        if (count == '0) begin
          state_next = ST_DONE;
        end else if (bits_left == '0) begin
          state_next = ST_FETCH;
        end else if (count_after == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_FETCH: begin
        state_next = (count_after == '0) ? ST_DONE : ST_STEP;
      end
      ST_DONE: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_len <= LEN_RESET;
      byte_pos   <= '0;
      ptr        <= '0;
      bits_left  <= '0;
      cur_byte   <= '0;
      resp_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        buffer_len <= cfg_wdata;
      end
      if (accept) begin
        kind       <= req.req_type;
        count      <= cnt_in;
        acc        <= '0;
        ovf        <= 1'b0;
        wsh        <= req.write_value << (COUNT_W'(MAX_BITS) - cnt_in);
        load_value <= req.byte_value;
        if (req.req_type == REQ_REWIND) begin
          byte_pos  <= '0;
          ptr       <= '0;
          bits_left <= '0;
          cur_byte  <= '0;
        end
      end
      if (fetch_need) begin
        fetch_addr <= ptr;
        ovf        <= ovf | (byte_pos >= buffer_len);
        byte_pos   <= byte_pos + 1'b1;
        ptr        <= ptr_inc;
      end
      if (step_go) begin
        cur_byte  <= byte_new;
        bits_left <= left_after;
        count     <= count_after;
        wsh       <= wsh << take;
        if (kind == REQ_READ) begin
          acc <= (acc << take) | {{(MAX_BITS-BYTE_BITS){1'b0}}, rd_bits};
        end
      end
      if (finish) begin
        resp_valid         <= 1'b1;
        resp.read_value    <= acc;
        resp.overflow      <= ovf;
        resp.next_byte_pos <= byte_pos;
      end else if (resp_valid && !resp_stall) begin
        resp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/msbbrw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msbbrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/msbbrw_addr_mod.sv =====
// Load address modulo buffer size, one remainder bit per cycle when serial.
module msbbrw_addr_mod import msbbrw_pkg::*; #(
  parameter int BUF_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ADDR_IN_W-1:0]         addr,
  output logic                         done,
  output logic [$clog2(BUF_BYTES)-1:0] rem
);

  localparam int AW = $clog2(BUF_BYTES);
  localparam bit DIRECT = (BUF_BYTES >= (1 << ADDR_IN_W)) ||
                          ((BUF_BYTES & (BUF_BYTES - 1)) == 0);

  generate
    if (DIRECT) begin : g_direct
      logic [AW+ADDR_IN_W-1:0] addr_ext;

      assign addr_ext = {{AW{1'b0}}, addr};

      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          rem <= addr_ext[AW-1:0];
        end
      end
    end else begin : g_serial
      localparam int CNT_W = $clog2(ADDR_IN_W + 1);
      localparam logic [AW:0] DIVISOR = (AW+1)'(BUF_BYTES);

      logic [ADDR_IN_W-1:0] bits;
      logic [CNT_W-1:0]     cnt;
      logic                 busy;
      logic [AW:0]          trial;
      logic [AW:0]          trial_red;

      assign trial     = {rem, bits[ADDR_IN_W-1]};
      assign trial_red = (trial >= DIVISOR) ? (trial - DIVISOR) : trial;

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
          cnt  <= '0;
        end else begin
          done <= busy && (cnt == CNT_W'(1));
          if (start) begin
            busy <= 1'b1;
            cnt  <= CNT_W'(ADDR_IN_W);
          end else if (busy) begin
            cnt <= cnt - 1'b1;
            if (cnt == CNT_W'(1)) begin
              busy <= 1'b0;
            end
          end
        end
        if (start) begin
          bits <= addr;
          rem  <= '0;
        end else if (busy) begin
          bits <= bits << 1;
          rem  <= trial_red[AW-1:0];
        end
      end
    end
  endgenerate

endmodule

// ===== design/msbbrw_checker.sv =====
// Port-level checker for the MSB-first bit-field reader/writer, with its bind.
`include "msb_first_bit_field_reader_writer_defines.svh"

module msbbrw_checker import msbbrw_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_stall,
  input req_t             req,
  input logic             resp_valid,
  input logic             resp_stall,
  input resp_t            resp
);

  `MSBBRW_ASSERT_NEXT_ALWAYS(a_reset_clears_resp, rst, !resp_valid)
  `MSBBRW_ASSERT_NEXT(a_busy_after_request, req_valid && !req_stall, req_stall)
  `MSBBRW_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req))
  `MSBBRW_ASSERT_NEXT(a_resp_hold, resp_valid && resp_stall, resp_valid && $stable(resp))

endmodule

bind msb_first_bit_field_reader_writer msbbrw_checker u_msbbrw_checker (.*);

// ===== bench/tb_msb_first_bit_field_reader_writer.sv =====
// Self-checking testbench for the MSB-first bit-field reader/writer.
`timescale 1ns / 100ps

module tb_msb_first_bit_field_reader_writer;
  import msbbrw_pkg::*;

  localparam int unsigned STORE_BYTES   = 4096;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 1500000;

  class bit_stream_model;
    logic [BYTE_BITS-1:0] mem [STORE_BYTES];
    logic [POS_W-1:0]     pos;
    int unsigned          left;
    logic [BYTE_BITS-1:0] cur;
    logic [LEN_W-1:0]     blen;
    int unsigned          fetches;
    int unsigned          overflows;
    int unsigned          checked;
    int unsigned          mismatches;
    resp_t                awaited [$];

    function new();
      foreach (mem[i]) mem[i] = '0;
      pos = '0;
      left = 0;
      cur = '0;
      blen = LEN_RESET;
      fetches = 0;
      overflows = 0;
      checked = 0;
      mismatches = 0;
    endfunction

    function bit fetch_byte();
      bit ovf;
      ovf = 1'b0;
      if (left == 0) begin
        cur = mem[pos[11:0]];
        left = BYTE_BITS;
        ovf = (pos >= blen);
        pos = pos + 13'd1;
        fetches++;
      end
      return ovf;
    endfunction

    function resp_t step_stream(req_t r);
      resp_t o;
      int unsigned n;
      int unsigned take;
      logic [31:0] acc;
      logic [31:0] chunk;
      logic [31:0] merged;
      logic [POS_W-1:0] back;
      o = '0;
      acc = '0;
      n = (r.bit_count > MAX_BITS) ? MAX_BITS : r.bit_count;
      case (r.req_type)
        REQ_LOAD: begin
          mem[r.byte_addr] = r.byte_value;
        end
        REQ_READ: begin
          while (n != 0) begin
            o.overflow |= fetch_byte();
            take = (left < n) ? left : n;
            acc = (acc << take) | ({24'd0, cur} >> (BYTE_BITS - take));
            cur = cur << take;
            left -= take;
            n -= take;
          end
          o.read_value = acc;
        end
        REQ_WRITE: begin
          while (n != 0) begin
            o.overflow |= fetch_byte();
            take = (left < n) ? left : n;
            chunk = (r.write_value >> (n - take)) & ((32'd1 << take) - 32'd1);
            merged = ({24'd0, cur} << take) | chunk;
            cur = merged[7:0];
            left -= take;
            n -= take;
            if (left == 0) begin
              back = pos - 13'd1;
              mem[back[11:0]] = cur;
            end
          end
        end
        REQ_REWIND: begin
          pos = '0;
          left = 0;
          cur = '0;
        end
      endcase
      o.next_byte_pos = pos;
      return o;
    endfunction

    function void note_request(req_t r);
      resp_t want;
      want = step_stream(r);
      if (want.overflow) overflows++;
      awaited.push_back(want);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 20) $display("MISMATCH: %s", what);
    endtask

    task check_response(resp_t got);
      resp_t want;
      if (awaited.size() == 0) begin
        report($sformatf("response with nothing outstanding: value %08h ovf %0d pos %0d",
                         got.read_value, got.overflow, got.next_byte_pos));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.read_value !== want.read_value)
        report($sformatf("response %0d read_value %08h, predicted %08h",
                         checked, got.read_value, want.read_value));
      if (got.overflow !== want.overflow)
        report($sformatf("response %0d overflow %0d, predicted %0d",
                         checked, got.overflow, want.overflow));
      if (got.next_byte_pos !== want.next_byte_pos)
        report($sformatf("response %0d next_byte_pos %0d, predicted %0d",
                         checked, got.next_byte_pos, want.next_byte_pos));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wen;
  logic [LEN_W-1:0] cfg_wdata;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             resp_valid;
  logic             resp_stall;
  resp_t            resp;

  bit_stream_model sb;
  bit_stream_model plan;
  bit              loaded [STORE_BYTES];
  bit              quiet;
  int unsigned     gap_pct;
  int unsigned     stall_pct;
  int unsigned     n_issued;
  int unsigned     kind_count [4];
  int unsigned     cycle_count;

  msb_first_bit_field_reader_writer #(.BUF_BYTES(STORE_BYTES)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid === 1'b1 && req_stall === 1'b0) sb.note_request(req);
      if (resp_valid === 1'b1 && resp_stall === 1'b0) sb.check_response(resp);
    end
  end

  initial begin
    resp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet || $urandom_range(0, 99) >= stall_pct) begin
        resp_stall = 1'b0;
      end else begin
        resp_stall = 1'b1;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end
    end
  end

  function automatic req_t make_req(req_kind_t kind, int unsigned addr, int unsigned val,
                                    int unsigned cnt, int unsigned wval);
    req_t r;
    r.req_type    = kind;
    r.byte_addr   = addr[11:0];
    r.byte_value  = val[7:0];
    r.bit_count   = cnt[5:0];
    r.write_value = wval;
    return r;
  endfunction

  function automatic int unsigned pick_count();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 8) return 0;
    if (p < 18) return $urandom_range(33, 63);
    if (p < 38) return 32;
    return $urandom_range(1, 31);
  endfunction

  function automatic int unsigned pick_pct();
    int unsigned p;
    p = $urandom_range(0, 2);
    return (p == 0) ? 0 : (p == 1) ? 10 : 35;
  endfunction

  // load every byte that this request is going to fetch but was never loaded
  task automatic fill_ahead(logic [COUNT_W-1:0] count);
    int unsigned n;
    int unsigned need;
    logic [POS_W-1:0] at;
    n = (count > MAX_BITS) ? MAX_BITS : count;
    need = (n > plan.left) ? (n - plan.left + 7) / 8 : 0;
    at = plan.pos;
    for (int unsigned i = 0; i < need; i++) begin
      if (!loaded[at[11:0]])
        issue(make_req(REQ_LOAD, at[11:0], $urandom, $urandom, $urandom));
      at = at + 13'd1;
    end
  endtask

  task automatic issue(req_t r);
    if (r.req_type == REQ_READ || r.req_type == REQ_WRITE) fill_ahead(r.bit_count);
    if (r.req_type == REQ_LOAD) loaded[r.byte_addr] = 1'b1;
    void'(plan.step_stream(r));
    kind_count[r.req_type]++;
    n_issued++;
    req_valid = 1'b1;
    req = r;
    do @(posedge clk); while (req_stall !== 1'b0);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_length(int unsigned len);
    drain();
    cfg_wen = 1'b1;
    cfg_wdata = len[LEN_W-1:0];
    @(negedge clk);
    cfg_wen = 1'b0;
    sb.blen = len[LEN_W-1:0];
    plan.blen = len[LEN_W-1:0];
  endtask

  task automatic run_sequences(int unsigned count);
    int unsigned stop;
    int unsigned p;
    stop = n_issued + count;
    while (n_issued < stop) begin
      p = $urandom_range(0, 99);
      if (p < 8)
        issue(make_req(REQ_REWIND, $urandom, $urandom, $urandom, $urandom));
      else if (p < 18)
        issue(make_req(REQ_LOAD, (p < 13) ? $urandom_range(0, 63) : $urandom,
                       $urandom, $urandom, $urandom));
      else if (p < 58)
        issue(make_req(REQ_READ, $urandom, $urandom, pick_count(), $urandom));
      else
        issue(make_req(REQ_WRITE, $urandom, $urandom, pick_count(), $urandom));
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned start;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    req_valid = 1'b0;
    req = '0;
    quiet = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    n_issued = 0;
    cycle_count = 0;
    sb = new();
    plan = new();
    repeat (3) @(negedge clk);
    rst = 1'b0;

    issue(make_req(REQ_LOAD, 0, 8'hFF, 0, 0));
    issue(make_req(REQ_LOAD, 1, 8'h00, 63, 32'hFFFFFFFF));
    issue(make_req(REQ_LOAD, 2, 8'hA5, 0, 0));
    issue(make_req(REQ_LOAD, 4095, 8'h81, 0, 0));
    issue(make_req(REQ_LOAD, 3, 8'h3C, 0, 0));
    issue(make_req(REQ_READ, 0, 0, 0, 0));
    issue(make_req(REQ_READ, 0, 0, 1, 0));
    issue(make_req(REQ_READ, 0, 0, 7, 0));
    issue(make_req(REQ_READ, 4095, 8'hFF, 32, 0));
    issue(make_req(REQ_REWIND, 0, 0, 0, 0));
    issue(make_req(REQ_READ, 0, 0, 63, 0));
    issue(make_req(REQ_REWIND, 4095, 8'hFF, 63, 32'hFFFFFFFF));
    issue(make_req(REQ_WRITE, 0, 0, 32, 32'hFFFFFFFF));
    issue(make_req(REQ_WRITE, 0, 0, 0, 32'hFFFFFFFF));
    issue(make_req(REQ_WRITE, 0, 0, 40, 32'h5A3C_C3A5));
    // a read leaves zeros behind in the byte that later writes complete
    issue(make_req(REQ_REWIND, 0, 0, 0, 0));
    issue(make_req(REQ_READ, 0, 0, 3, 0));
    issue(make_req(REQ_WRITE, 0, 0, 5, 32'h0000001F));
    issue(make_req(REQ_REWIND, 0, 0, 0, 0));
    issue(make_req(REQ_READ, 0, 0, 8, 0));
    set_length(0);
    issue(make_req(REQ_REWIND, 0, 0, 0, 0));
    issue(make_req(REQ_READ, 0, 0, 8, 0));
    issue(make_req(REQ_WRITE, 0, 0, 4, 32'h00000009));
    issue(make_req(REQ_READ, 0, 0, 4, 0));
    issue(make_req(REQ_WRITE, 0, 0, 12, 32'h00000ABC));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: len = 4096;
        1: len = 0;
        2: len = $urandom_range(1, 64);
        3: len = $urandom_range(0, 4096);
        4: len = 16;
        5: len = $urandom_range(1, 64);
        6: len = 4095;
        default: len = 1;
      endcase
      set_length(len);
      gap_pct = pick_pct();
      stall_pct = pick_pct();
      run_sequences(150);
    end

    // stream at least 256 bytes from the start with long fields
    set_length(4096);
    gap_pct = 4;
    stall_pct = 4;
    issue(make_req(REQ_REWIND, 0, 0, 0, 0));
    start = plan.fetches;
    while (plan.fetches - start < 256)
      issue(make_req($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, $urandom, $urandom,
                     $urandom_range(24, 32), $urandom));

    set_length($urandom_range(0, 64));
    quiet = 1'b1;
    run_sequences(150);

    drain();
    $display("Sent %0d requests: %0d loads, %0d reads, %0d writes, %0d rewinds.",
             n_issued, kind_count[REQ_LOAD], kind_count[REQ_READ],
             kind_count[REQ_WRITE], kind_count[REQ_REWIND]);
    $display("Compared %0d responses, %0d with overflow, over %0d byte fetches.",
             sb.checked, sb.overflows, sb.fetches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
